>>> hdl/bfw_pkg.sv
// ----------------------------------------------------------------------------
// bfw_pkg
// Shared types and codes for the windowed bilateral filter.
// ----------------------------------------------------------------------------
package bfw_pkg;

   localparam int CHANNELS  = 3;
   localparam int DIV_STEPS = 8;

   localparam logic [1:0] ACT_PIXEL   = 2'd0;
   localparam logic [1:0] ACT_COLOUR  = 2'd1;
   localparam logic [1:0] ACT_SPATIAL = 2'd2;

   localparam logic REG_IMAGE_WIDTH = 1'b0;

   localparam logic [10:0] IMAGE_WIDTH_RESET = 11'd640;

   typedef logic [CHANNELS-1:0][7:0] pixel_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FETCH,
      ST_MAC,
      ST_DIV,
      ST_HOLD
   } seq_state_type;

   typedef struct packed {
      logic rd;
      logic upd;
      logic above;
   } win_ctl_type;

   typedef struct packed {
      logic clear;
      logic tap_valid;
      logic div_load;
      logic div_step;
   } lane_ctl_type;

endpackage

>>> hdl/bfw_channels.sv
// ----------------------------------------------------------------------------
// bfw channels
// Handshake interfaces for the pixel input words and the filtered result words.
// ----------------------------------------------------------------------------
interface bfw_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  action;
   logic        frame_start;
   logic [7:0]  weight_index;
   logic [15:0] weight_value;
   logic [7:0]  blue_in;
   logic [7:0]  green_in;
   logic [7:0]  red_in;

   modport source (output valid, action, frame_start, weight_index, weight_value,
                   blue_in, green_in, red_in, input ready);
   modport sink (input valid, action, frame_start, weight_index, weight_value,
                 blue_in, green_in, red_in, output ready);
endinterface

interface bfw_rsp_if;
   logic        valid;
   logic        ready;
   logic [11:0] out_row;
   logic [9:0]  out_col;
   logic [7:0]  blue_out;
   logic [7:0]  green_out;
   logic [7:0]  red_out;

   modport source (output valid, out_row, out_col, blue_out, green_out, red_out,
                   input ready);
   modport sink (input valid, out_row, out_col, blue_out, green_out, red_out,
                 output ready);
endinterface

>>> hdl/bfw_window.sv
// ----------------------------------------------------------------------------
// bfw_window
// Line store and sliding window registers for all three channels.
// ----------------------------------------------------------------------------
module bfw_window
   import bfw_pkg::*;
#(
   parameter int WINDOW    = 5,
   parameter int MAX_WIDTH = 1024
) (
   input  logic                                      clock,
   input  logic                                      reset,
   input  win_ctl_type                               ctl,
   input  logic [$clog2(MAX_WIDTH)-1:0]              addr,
   input  pixel_type                                 pixel,
   output logic [CHANNELS-1:0][WINDOW*WINDOW-1:0][7:0] taps
);

   localparam int TAPS = WINDOW * WINDOW;

   typedef logic [WINDOW-2:0][CHANNELS-1:0][7:0] ls_word_type;

   ls_word_type ls_mem [MAX_WIDTH];
   ls_word_type ls_rd_ff;
   ls_word_type ls_wr;
   logic [CHANNELS-1:0][TAPS-1:0][7:0] win_ff;

   always_comb begin
      for (int i = 0; i < WINDOW - 2; i++) begin
         ls_wr[i] = ls_rd_ff[i+1];
      end
      ls_wr[WINDOW-2] = pixel;
   end

   always_ff @(posedge clock) begin
      if (ctl.rd) begin
         ls_rd_ff <= ls_mem[addr];
      end
      if (ctl.upd) begin
         ls_mem[addr] <= ls_wr;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         win_ff <= '0;
      end else if (ctl.upd) begin
         for (int c = 0; c < CHANNELS; c++) begin
            for (int i = 0; i < WINDOW; i++) begin
               for (int j = 0; j < WINDOW - 1; j++) begin
                  win_ff[c][i*WINDOW+j] <= win_ff[c][i*WINDOW+j+1];
               end
               if (i < WINDOW - 1) begin
                  win_ff[c][i*WINDOW+WINDOW-1] <= ctl.above ? ls_rd_ff[i][c] : 8'd0;
               end else begin
                  win_ff[c][i*WINDOW+WINDOW-1] <= pixel[c];
               end
            end
         end
      end
   end

   assign taps = win_ff;

endmodule

>>> hdl/bfw_lane.sv
// ----------------------------------------------------------------------------
// bfw_lane
// One channel: weight lookup, multiply-accumulate over the taps and divide.
// ----------------------------------------------------------------------------
module bfw_lane
   import bfw_pkg::*;
#(
   parameter int WINDOW      = 5,
   parameter int WEIGHT_BITS = 16
) (
   input  logic                               clock,
   input  logic                               reset,
   input  lane_ctl_type                       ctl,
   input  logic [$clog2(WINDOW*WINDOW)-1:0]   tap,
   input  logic [WINDOW*WINDOW-1:0][7:0]      taps,
   input  logic [WEIGHT_BITS-1:0]             spatial_weight,
   input  logic                               cw_we,
   input  logic [7:0]                         cw_addr,
   input  logic [WEIGHT_BITS-1:0]             cw_data,
   output logic [7:0]                         result
);

   localparam int TAPS    = WINDOW * WINDOW;
   localparam int CTR_IDX = (WINDOW / 2) * WINDOW + WINDOW / 2;
   localparam int PW      = 2 * WEIGHT_BITS;
   localparam int DENW    = PW + $clog2(TAPS);
   localparam int NUMW    = DENW + 8;

   logic [WEIGHT_BITS-1:0] cw_mem [256];
   logic [WEIGHT_BITS-1:0] cw_rd_ff;
   logic [7:0]             v_sel;
   logic [7:0]             ctr_v;
   logic [7:0]             diff;
   logic [7:0]             v_a_ff;
   logic [7:0]             v_b_ff;
   logic                   valid_a_ff;
   logic                   valid_b_ff;
   logic                   valid_c_ff;
   logic [PW-1:0]          w_b_ff;
   logic [PW-1:0]          w_c_ff;
   logic [PW+7:0]          p_c_ff;
   logic [DENW-1:0]        den_ff;
   logic [NUMW-1:0]        num_ff;
   logic [NUMW-1:0]        rem_ff;
   logic [NUMW-1:0]        dsh_ff;
   logic [7:0]             q_ff;
   logic                   dz_ff;

   assign v_sel = taps[tap];
   assign ctr_v = taps[CTR_IDX];
   assign diff  = (v_sel > ctr_v) ? (v_sel - ctr_v) : (ctr_v - v_sel);

   always_ff @(posedge clock) begin
      if (cw_we) begin
         cw_mem[cw_addr] <= cw_data;
      end
      if (ctl.tap_valid) begin
         cw_rd_ff <= cw_mem[diff];
         v_a_ff   <= v_sel;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_a_ff <= 1'b0;
         valid_b_ff <= 1'b0;
         valid_c_ff <= 1'b0;
      end else begin
         valid_a_ff <= ctl.tap_valid;
         valid_b_ff <= valid_a_ff;
         valid_c_ff <= valid_b_ff;
      end
   end

   always_ff @(posedge clock) begin
      w_b_ff <= {{WEIGHT_BITS{1'b0}}, spatial_weight} * {{WEIGHT_BITS{1'b0}}, cw_rd_ff};
      v_b_ff <= v_a_ff;
      p_c_ff <= {8'd0, w_b_ff} * {{PW{1'b0}}, v_b_ff};
      w_c_ff <= w_b_ff;
   end

   always_ff @(posedge clock) begin
      if (ctl.clear) begin
         num_ff <= '0;
         den_ff <= '0;
      end else if (valid_c_ff) begin
         num_ff <= num_ff + NUMW'(p_c_ff);
         den_ff <= den_ff + DENW'(w_c_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.div_load) begin
         rem_ff <= num_ff;
         dsh_ff <= {1'b0, den_ff, 7'd0};
         q_ff   <= '0;
         dz_ff  <= (den_ff == '0);
      end else if (ctl.div_step) begin
         if (rem_ff >= dsh_ff) begin
            rem_ff <= rem_ff - dsh_ff;
            q_ff   <= {q_ff[6:0], 1'b1};
         end else begin
            q_ff   <= {q_ff[6:0], 1'b0};
         end
         dsh_ff <= dsh_ff >> 1;
      end
   end

   assign result = dz_ff ? 8'd0 : q_ff;

endmodule

>>> hdl/bfw_merge.sv
// ----------------------------------------------------------------------------
// bfw_merge
// Gathers the three lane results with the centre coordinates into the
// output register.
// ----------------------------------------------------------------------------
module bfw_merge
   import bfw_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          load,
   input  logic [11:0]   row,
   input  logic [9:0]    col,
   input  pixel_type     values,
   output logic          busy,
   bfw_rsp_if.source     rsp_if
);

   logic        valid_ff;
   logic        valid_in;
   logic [11:0] row_ff;
   logic [9:0]  col_ff;
   pixel_type   values_ff;

   assign busy     = valid_ff && !rsp_if.ready;
   assign valid_in = load || busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         row_ff    <= row;
         col_ff    <= col;
         values_ff <= values;
      end
   end

   assign rsp_if.valid     = valid_ff;
   assign rsp_if.out_row   = row_ff;
   assign rsp_if.out_col   = col_ff;
   assign rsp_if.blue_out  = values_ff[0];
   assign rsp_if.green_out = values_ff[1];
   assign rsp_if.red_out   = values_ff[2];

endmodule

>>> hdl/bilateral_filter_window.sv
// A pixel that completes the window passes through the fetch, multiply-accumulate,
// divide and hold states before its result is loaded into the output register.
// Such a pixel occupies the block until it returns to idle, held by the tap-serial
// multiply-accumulate in each lane, the 8-step divider and a stalled output; other
// pixels pass through the fetch state only, and weight loads keep the block idle.
// Reset clears the window, counters and handshakes and sets the width to 640.
// ----------------------------------------------------------------------------
// bilateral_filter_window
// Streaming three-channel bilateral filter with line stores and
// per-channel lanes.
// ----------------------------------------------------------------------------
module bilateral_filter_window
   import bfw_pkg::*;
#(
   parameter int WINDOW      = 5,
   parameter int MAX_WIDTH   = 1024,
   parameter int WEIGHT_BITS = 16
) (
   input  logic         clock,
   input  logic         reset,
   bfw_req_if.sink      req_if,
   bfw_rsp_if.source    rsp_if,
   input  logic         csr_psel,
   input  logic         csr_penable,
   input  logic         csr_pwrite,
   input  logic [2:0]   csr_paddr,
   input  logic [31:0]  csr_pwdata,
   output logic [31:0]  csr_prdata,
   output logic         csr_pready
);

   localparam int TAPS = WINDOW * WINDOW;
   localparam int TAW  = $clog2(TAPS);
   localparam int CNTW = $clog2(TAPS + 3);
   localparam int LAW  = $clog2(MAX_WIDTH);
   localparam int CTR  = WINDOW / 2;
   localparam logic [CNTW-1:0] MAC_LAST = CNTW'(TAPS + 2);
   localparam logic [CNTW-1:0] DIV_LAST = CNTW'(DIV_STEPS);
   localparam logic [CNTW-1:0] TAPS_C   = CNTW'(TAPS);

   seq_state_type state_ff, state_in;

   logic [10:0]      width_ff;
   logic [12:0]      w_use;
   logic [LAW-1:0]   col_ff, col_in;
   logic [11:0]      row_ff, row_in;
   logic [LAW-1:0]   x_ff, x_new;
   logic [11:0]      y_ff, y_new;
   pixel_type        px_ff;
   logic             above_ff;
   logic             produce_ff;
   logic [CNTW-1:0]  cnt_ff, cnt_in;
   logic [12:0]      c0, c1;
   logic [11:0]      r0;
   logic             wrap0, wrap1;
   logic             accept;
   logic             pixel_acc;
   logic             mbusy;
   logic             mload;
   logic [11:0]      out_row;
   logic [12:0]      out_col_w;
   logic [WEIGHT_BITS+15:0] wv_ext;
   logic [WEIGHT_BITS-1:0]  wv;
   logic [WEIGHT_BITS-1:0]  sw_mem [TAPS];
   logic [WEIGHT_BITS-1:0]  sw_rd_ff;
   logic [TAW-1:0]   tap;
   logic [LAW-1:0]   ls_addr;
   pixel_type        lane_res;
   win_ctl_type      wctl;
   lane_ctl_type     lctl;
   logic [CHANNELS-1:0][TAPS-1:0][7:0] taps;

   // Configuration port.
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[2] == REG_IMAGE_WIDTH) ? {21'd0, width_ff} : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff <= IMAGE_WIDTH_RESET;
      end else if (csr_psel && csr_penable && csr_pwrite && csr_pready &&
                   csr_paddr[2] == REG_IMAGE_WIDTH) begin
         width_ff <= csr_pwdata[10:0];
      end
   end

   assign w_use = (width_ff == 11'd0) ? 13'd1 :
                  (13'(width_ff) > 13'(MAX_WIDTH)) ? 13'(MAX_WIDTH) : 13'(width_ff);

   assign accept    = req_if.valid && req_if.ready;
   assign pixel_acc = accept && (req_if.action == ACT_PIXEL);

   // Column and row bookkeeping for an incoming pixel.
   always_comb begin
      c0    = req_if.frame_start ? 13'd0 : 13'(col_ff);
      r0    = req_if.frame_start ? 12'd0 : row_ff;
      wrap0 = (c0 >= w_use);
      x_new = wrap0 ? '0 : c0[LAW-1:0];
      y_new = wrap0 ? r0 + 12'd1 : r0;
      c1    = 13'(x_new) + 13'd1;
      wrap1 = (c1 >= w_use);
      col_in = wrap1 ? '0 : c1[LAW-1:0];
      row_in = wrap1 ? y_new + 12'd1 : y_new;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else if (pixel_acc) begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pixel_acc) begin
         x_ff       <= x_new;
         y_ff       <= y_new;
         px_ff      <= {req_if.red_in, req_if.green_in, req_if.blue_in};
         above_ff   <= (y_new != 12'd0);
         produce_ff <= (y_new >= 12'(WINDOW - 1)) && (13'(x_new) >= 13'(WINDOW - 1));
      end
   end

   // Weight loads.
   assign wv_ext = {{WEIGHT_BITS{1'b0}}, req_if.weight_value};
   assign wv     = wv_ext[WEIGHT_BITS-1:0];
   assign tap    = cnt_ff[TAW-1:0];

   always_ff @(posedge clock) begin
      if (accept && req_if.action == ACT_SPATIAL &&
          9'(req_if.weight_index) < 9'(TAPS)) begin
         sw_mem[req_if.weight_index[TAW-1:0]] <= wv;
      end
      if (lctl.tap_valid) begin
         sw_rd_ff <= sw_mem[tap];
      end
   end

   // Sequencer.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      case (state_ff)
         ST_IDLE: begin
            if (pixel_acc) begin
               state_in = ST_FETCH;
            end
         end
         ST_FETCH: begin
            cnt_in   = '0;
            state_in = produce_ff ? ST_MAC : ST_IDLE;
         end
         ST_MAC: begin
            if (cnt_ff == MAC_LAST) begin
               cnt_in   = '0;
               state_in = ST_DIV;
            end else begin
               cnt_in = cnt_ff + CNTW'(1);
            end
         end
         ST_DIV: begin
            cnt_in = cnt_ff + CNTW'(1);
            if (cnt_ff == DIV_LAST) begin
               state_in = ST_HOLD;
            end
         end
         ST_HOLD: begin
            if (!mbusy) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      req_if.ready = 1'b0;
      wctl         = '0;
      lctl         = '0;
      mload        = 1'b0;
      ls_addr      = x_ff;
      case (state_ff)
         ST_IDLE: begin
            req_if.ready = 1'b1;
            wctl.rd      = pixel_acc;
            ls_addr      = x_new;
         end
         ST_FETCH: begin
            wctl.upd   = 1'b1;
            wctl.above = above_ff;
            lctl.clear = 1'b1;
         end
         ST_MAC: begin
            lctl.tap_valid = (cnt_ff < TAPS_C);
         end
         ST_DIV: begin
            lctl.div_load = (cnt_ff == '0);
            lctl.div_step = (cnt_ff != '0);
         end
         ST_HOLD: begin
            mload = !mbusy;
         end
         default: begin
            req_if.ready = 1'b0;
         end
      endcase
   end

   bfw_window #(
      .WINDOW    (WINDOW),
      .MAX_WIDTH (MAX_WIDTH)
   ) u_window (
      .clock (clock),
      .reset (reset),
      .ctl   (wctl),
      .addr  (ls_addr),
      .pixel (px_ff),
      .taps  (taps)
   );

   for (genvar c = 0; c < CHANNELS; c++) begin : g_lane
      bfw_lane #(
         .WINDOW      (WINDOW),
         .WEIGHT_BITS (WEIGHT_BITS)
      ) u_lane (
         .clock          (clock),
         .reset          (reset),
         .ctl            (lctl),
         .tap            (tap),
         .taps           (taps[c]),
         .spatial_weight (sw_rd_ff),
         .cw_we          (accept && req_if.action == ACT_COLOUR),
         .cw_addr        (req_if.weight_index),
         .cw_data        (wv),
         .result         (lane_res[c])
      );
   end

   assign out_row   = y_ff - 12'(CTR);
   assign out_col_w = 13'(x_ff) - 13'(CTR);

   bfw_merge u_merge (
      .clock  (clock),
      .reset  (reset),
      .load   (mload),
      .row    (out_row),
      .col    (out_col_w[9:0]),
      .values (lane_res),
      .busy   (mbusy),
      .rsp_if (rsp_if)
   );

endmodule

>>> sim/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives pixel and weight-load words into the windowed bilateral filter while
// an internal prediction of the line stores, window and weight tables computes
// every filtered result, which is then checked word by word at the output.
// ----------------------------------------------------------------------------
module testbench
   import bfw_pkg::*;
();

   localparam int WIN            = 5;
   localparam int HALF           = WIN / 2;
   localparam int TAP_COUNT      = WIN * WIN;
   localparam int MAXW           = 1024;
   localparam int SETTLE_CYCLES  = 60;
   localparam int HOLD_CYCLES    = 400;
   localparam int WATCHDOG_LIMIT = 5000;

   localparam logic [1:0] ACT_UNKNOWN = 2'd3;

   typedef struct packed {
      logic [1:0]  action;
      logic        frame_start;
      logic [7:0]  weight_index;
      logic [15:0] weight_value;
      logic [7:0]  blue;
      logic [7:0]  green;
      logic [7:0]  red;
   } pixel_word_type;

   typedef struct packed {
      logic [11:0] row;
      logic [9:0]  col;
      logic [7:0]  blue;
      logic [7:0]  green;
      logic [7:0]  red;
   } filtered_word_type;

   logic        clock;
   logic        reset;
   logic        csr_psel;
   logic        csr_penable;
   logic        csr_pwrite;
   logic [2:0]  csr_paddr;
   logic [31:0] csr_pwdata;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   bfw_req_if req_bus ();
   bfw_rsp_if rsp_bus ();

   bilateral_filter_window i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_if      (req_bus),
      .rsp_if      (rsp_bus),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   logic [7:0]  line_mem [WIN-1][MAXW][CHANNELS];
   logic [7:0]  win_taps [WIN][WIN][CHANNELS];
   logic [15:0] colour_lut [256];
   logic [15:0] spatial_lut [TAP_COUNT];
   int unsigned cur_col;
   int unsigned cur_row;
   logic [10:0] width_setting;

   filtered_word_type pending_pixels [$];
   int  mismatches = 0;
   int  idle_cycles;
   bit  calm;
   bit  hold_request;
   bit  hold_done;

   pixel_word_type directed_table [15] = '{
      '{ACT_COLOUR,  1'b0, 8'd0,   16'hFFFF, 8'd0,   8'd0,   8'd0},
      '{ACT_COLOUR,  1'b0, 8'd255, 16'h0000, 8'd0,   8'd0,   8'd0},
      '{ACT_COLOUR,  1'b1, 8'd128, 16'h0001, 8'd0,   8'd0,   8'd0},
      '{ACT_SPATIAL, 1'b0, 8'd0,   16'hFFFF, 8'd0,   8'd0,   8'd0},
      '{ACT_SPATIAL, 1'b0, 8'd24,  16'h0000, 8'd0,   8'd0,   8'd0},
      '{ACT_SPATIAL, 1'b1, 8'd12,  16'h8000, 8'd0,   8'd0,   8'd0},
      '{ACT_SPATIAL, 1'b0, 8'd25,  16'h1234, 8'd0,   8'd0,   8'd0},
      '{ACT_SPATIAL, 1'b0, 8'd255, 16'hFFFF, 8'd0,   8'd0,   8'd0},
      '{ACT_UNKNOWN, 1'b1, 8'd255, 16'hFFFF, 8'd255, 8'd255, 8'd255},
      '{ACT_PIXEL,   1'b1, 8'd0,   16'h0000, 8'd0,   8'd0,   8'd0},
      '{ACT_PIXEL,   1'b0, 8'd0,   16'h0000, 8'd255, 8'd255, 8'd255},
      '{ACT_PIXEL,   1'b0, 8'd0,   16'h0000, 8'd0,   8'd255, 8'd0},
      '{ACT_PIXEL,   1'b0, 8'd0,   16'h0000, 8'd170, 8'd85,  8'd1},
      '{ACT_PIXEL,   1'b1, 8'd7,   16'hABCD, 8'd128, 8'd127, 8'd254},
      '{ACT_PIXEL,   1'b0, 8'd0,   16'h0000, 8'd255, 8'd0,   8'd255}
   };

   initial clock = 1'b0;
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic logic [7:0] filter_lane(input int c);
      logic [63:0] num;
      logic [63:0] den;
      logic [63:0] wt;
      logic [7:0]  cv;
      logic [7:0]  v;
      logic [7:0]  d;
      cv  = win_taps[HALF][HALF][c];
      num = '0;
      den = '0;
      for (int i = 0; i < WIN; i++) begin
         for (int j = 0; j < WIN; j++) begin
            v   = win_taps[i][j][c];
            d   = (v > cv) ? v - cv : cv - v;
            wt  = 64'(spatial_lut[i*WIN+j]) * 64'(colour_lut[d]);
            num += wt * 64'(v);
            den += wt;
         end
      end
      return (den == 0) ? 8'd0 : 8'(num / den);
   endfunction

   function automatic bit predict_filter(input pixel_word_type w,
                                         output filtered_word_type r);
      int unsigned wd;
      int unsigned x;
      int unsigned y;
      logic [7:0]  px [CHANNELS];
      r = '0;
      if (w.action == ACT_COLOUR) begin
         colour_lut[w.weight_index] = w.weight_value;
         return 1'b0;
      end
      if (w.action == ACT_SPATIAL) begin
         if (w.weight_index < TAP_COUNT) spatial_lut[w.weight_index] = w.weight_value;
         return 1'b0;
      end
      if (w.action != ACT_PIXEL) return 1'b0;
      wd = (width_setting == 0) ? 1 : ((width_setting > MAXW) ? MAXW : width_setting);
      if (w.frame_start) begin
         cur_col = 0;
         cur_row = 0;
      end
      if (cur_col >= wd) begin
         cur_col = 0;
         cur_row = (cur_row + 1) % 4096;
      end
      x = cur_col;
      y = cur_row;
      px[0] = w.blue;
      px[1] = w.green;
      px[2] = w.red;
      for (int i = 0; i < WIN; i++)
         for (int j = 0; j < WIN - 1; j++)
            for (int c = 0; c < CHANNELS; c++) win_taps[i][j][c] = win_taps[i][j+1][c];
      for (int i = 0; i < WIN - 1; i++)
         for (int c = 0; c < CHANNELS; c++)
            win_taps[i][WIN-1][c] = (y >= 1) ? line_mem[i][x][c] : 8'd0;
      for (int c = 0; c < CHANNELS; c++) win_taps[WIN-1][WIN-1][c] = px[c];
      for (int i = 0; i < WIN - 2; i++)
         for (int c = 0; c < CHANNELS; c++) line_mem[i][x][c] = line_mem[i+1][x][c];
      for (int c = 0; c < CHANNELS; c++) line_mem[WIN-2][x][c] = px[c];
      cur_col = x + 1;
      if (cur_col >= wd) begin
         cur_col = 0;
         cur_row = (cur_row + 1) % 4096;
      end
      if (y >= WIN - 1 && x >= WIN - 1) begin
         r.row   = 12'(y - HALF);
         r.col   = 10'(x - HALF);
         r.blue  = filter_lane(0);
         r.green = filter_lane(1);
         r.red   = filter_lane(2);
         return 1'b1;
      end
      return 1'b0;
   endfunction

   function automatic pixel_word_type random_word();
      pixel_word_type w;
      int sel;
      sel            = $urandom_range(0, 99);
      w.frame_start  = 1'($urandom_range(0, 1));
      w.weight_index = 8'($urandom);
      w.weight_value = 16'($urandom);
      w.blue         = 8'($urandom);
      w.green        = 8'($urandom);
      w.red          = 8'($urandom);
      if (sel < 82) begin
         w.action      = ACT_PIXEL;
         w.frame_start = ($urandom_range(0, 199) == 0);
         if (sel < 6) begin
            w.blue  = $urandom_range(0, 1) ? 8'd255 : 8'd0;
            w.green = $urandom_range(0, 1) ? 8'd255 : 8'd0;
            w.red   = $urandom_range(0, 1) ? 8'd255 : 8'd0;
         end
      end else if (sel < 90) begin
         w.action = ACT_COLOUR;
      end else if (sel < 97) begin
         w.action = ACT_SPATIAL;
         if ($urandom_range(0, 3) != 0) begin
            w.weight_index = 8'($urandom_range(0, TAP_COUNT - 1));
         end
      end else begin
         w.action = ACT_UNKNOWN;
      end
      return w;
   endfunction

   task automatic send_word(input pixel_word_type w);
      filtered_word_type r;
      req_bus.valid        <= 1'b1;
      req_bus.action       <= w.action;
      req_bus.frame_start  <= w.frame_start;
      req_bus.weight_index <= w.weight_index;
      req_bus.weight_value <= w.weight_value;
      req_bus.blue_in      <= w.blue;
      req_bus.green_in     <= w.green;
      req_bus.red_in       <= w.red;
      do @(posedge clock); while (!req_bus.ready);
      if (predict_filter(w, r)) pending_pixels.push_back(r);
      if (!calm && $urandom_range(0, 7) == 0) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 13)) @(posedge clock);
      end
   endtask

   task automatic load_weight(input logic [1:0] action, input int index, input logic [15:0] value);
      pixel_word_type w;
      w              = random_word();
      w.action       = action;
      w.weight_index = 8'(index);
      w.weight_value = value;
      send_word(w);
   endtask

   task automatic run_random(input int count);
      for (int n = 0; n < count; n++) send_word(random_word());
   endtask

   task automatic run_pixels(input int count);
      pixel_word_type w;
      for (int n = 0; n < count; n++) begin
         w             = random_word();
         w.action      = ACT_PIXEL;
         w.frame_start = (n == 0);
         send_word(w);
      end
   endtask

   task automatic drain();
      req_bus.valid <= 1'b0;
      while (pending_pixels.size() > 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_width(input logic [10:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= 3'(4 * REG_IMAGE_WIDTH);
      csr_pwdata  <= 32'(value);
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel      <= 1'b0;
      csr_penable   <= 1'b0;
      csr_pwrite    <= 1'b0;
      width_setting  = value;
   endtask

   initial begin
      reset                <= 1'b1;
      csr_psel             <= 1'b0;
      csr_penable          <= 1'b0;
      csr_pwrite           <= 1'b0;
      csr_paddr            <= '0;
      csr_pwdata           <= '0;
      req_bus.valid        <= 1'b0;
      req_bus.action       <= ACT_PIXEL;
      req_bus.frame_start  <= 1'b0;
      req_bus.weight_index <= '0;
      req_bus.weight_value <= '0;
      req_bus.blue_in      <= '0;
      req_bus.green_in     <= '0;
      req_bus.red_in       <= '0;
      calm          = 1'b0;
      hold_request  = 1'b0;
      cur_col       = 0;
      cur_row       = 0;
      width_setting = IMAGE_WIDTH_RESET;
      foreach (line_mem[i, j, c]) line_mem[i][j][c] = '0;
      foreach (win_taps[i, j, c]) win_taps[i][j][c] = '0;
      foreach (colour_lut[i]) colour_lut[i] = '0;
      foreach (spatial_lut[i]) spatial_lut[i] = '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Every weight entry is written before any result can read it.
      for (int i = 0; i < 256; i++) load_weight(ACT_COLOUR, i, 16'($urandom));
      for (int i = 0; i < TAP_COUNT; i++) load_weight(ACT_SPATIAL, i, 16'($urandom));
      foreach (directed_table[k]) send_word(directed_table[k]);
      drain();

      write_width(11'd8);
      run_random(150);
      for (int i = 0; i < TAP_COUNT; i++) load_weight(ACT_SPATIAL, i, 16'h0000);
      run_pixels(48);
      for (int i = 0; i < TAP_COUNT; i++) load_weight(ACT_SPATIAL, i, 16'($urandom));
      hold_request = 1'b1;
      run_random(120);
      drain();

      // Stop in the middle of a wide row, then narrow the row below the column.
      write_width(11'd13);
      run_pixels(13 * 5 + 10);
      drain();
      write_width(11'd8);
      run_random(150);
      drain();

      // A zero width gives one pixel per row.
      write_width(11'd0);
      run_pixels(60);
      drain();
      write_width(11'd8);
      run_random(100);
      drain();

      write_width(11'd2047);
      run_random(60);
      drain();
      write_width(11'd1024);
      run_random(60);
      drain();
      write_width(11'd9);
      run_random(60);
      drain();
      write_width(11'd8);
      calm = 1'b1;
      run_random(100);
      drain();

      if (mismatches == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

   initial begin
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (calm) begin
            rsp_bus.ready <= 1'b1;
         end else if (hold_request && !hold_done) begin
            rsp_bus.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_done = 1'b1;
         end else if ($urandom_range(0, 9) == 0) begin
            rsp_bus.ready <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge clock);
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      filtered_word_type exp_word;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (pending_pixels.size() == 0) begin
            $error("result word with none expected: row %0d col %0d",
                   rsp_bus.out_row, rsp_bus.out_col);
            mismatches++;
         end else begin
            exp_word = pending_pixels.pop_front();
            if (rsp_bus.out_row !== exp_word.row) begin
               $error("out_row: expected %0d, got %0d", exp_word.row, rsp_bus.out_row);
               mismatches++;
            end
            if (rsp_bus.out_col !== exp_word.col) begin
               $error("out_col: expected %0d, got %0d", exp_word.col, rsp_bus.out_col);
               mismatches++;
            end
            if (rsp_bus.blue_out !== exp_word.blue) begin
               $error("blue_out: expected %0d, got %0d", exp_word.blue, rsp_bus.blue_out);
               mismatches++;
            end
            if (rsp_bus.green_out !== exp_word.green) begin
               $error("green_out: expected %0d, got %0d", exp_word.green, rsp_bus.green_out);
               mismatches++;
            end
            if (rsp_bus.red_out !== exp_word.red) begin
               $error("red_out: expected %0d, got %0d", exp_word.red, rsp_bus.red_out);
               mismatches++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)
          || csr_psel) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

endmodule

>>> filelist.f
hdl/bfw_pkg.sv
hdl/bfw_channels.sv
hdl/bfw_window.sv
hdl/bfw_lane.sv
hdl/bfw_merge.sv
hdl/bilateral_filter_window.sv
sim/testbench.sv
